// ===== design/fla_pkg.sv =====
// Shared constants, codes and types of the free-list page allocator.
package fla_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int TOTAL_W   = PAGE_W + 1;
  localparam int GROW_W    = 8;
  localparam int STATUS_W  = 2;

  localparam logic [GROW_W-1:0] GROW_RESET = GROW_W'(100);

  // Request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_PAGE = 2'd2;

  typedef struct packed {
    logic [TOTAL_W-1:0]  total_pages;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   result_page;
  } fla_result_t;

endpackage

// ===== design/free_list_page_allocator.sv =====
// Free-list page allocator: one request in, one result out, links in on-chip memory.
// No new request is accepted until the last result is handed to the output register; a
// free, a pop from the list or an out-of-space reply is answered from the execute state,
// while a pop that grows the pool may link new pages in the growth state and answers from the final state.
// Reset: synchronous, active high; empty list, header page only, grow count 100.
// The link memory is not cleared; no clearing pass follows reset.
module free_list_page_allocator
  import fla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // [9:0] page_number, rest zero
  input  logic                s_tuser,   // [0] mode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,   // [9:0] result_page, [11:10] status,
                                         // [22:12] total_pages, rest zero
  input  logic                cfg_wen,
  input  logic [GROW_W-1:0]   cfg_wdata
);

  logic [GROW_W-1:0] grow_count;
  logic              res_valid;
  logic              res_ready;
  fla_result_t       res;
  fla_result_t       out_q;
  logic              ram_re;
  logic [PAGE_W-1:0] ram_raddr;
  logic [PAGE_W-1:0] ram_rdata;
  logic              ram_we;
  logic [PAGE_W-1:0] ram_waddr;
  logic [PAGE_W-1:0] ram_wdata;

  // Growth size register
  always_ff @(posedge clk) begin
    if (rst) begin
      grow_count <= GROW_RESET;
    end else if (cfg_wen) begin
      grow_count <= cfg_wdata;
    end
  end

  fla_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_mode   (s_tuser),
    .req_page   (s_tdata[PAGE_W-1:0]),
    .grow_count (grow_count),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  fla_link_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (PAGE_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: free when empty or being taken
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {1'b0, out_q};

`ifndef SYNTHESIS
  // An accepted request blocks the input in the cycle after the accept
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted on consecutive cycles");

  // Pool size stays within the header page and the capacity
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_q.total_pages != '0) && (out_q.total_pages <= TOTAL_W'(MAX_PAGES)))
    else $error("total_pages out of range");

  // Failed requests never hand out a page
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((out_q.status == STATUS_NO_SPACE) || (out_q.status == STATUS_BAD_PAGE))
      |-> (out_q.result_page == '0))
    else $error("page returned with error status");
`endif

endmodule

// ===== design/fla_link_ram.sv =====
// Single-port-write, single-port-read link memory with registered read data.
module fla_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/fla_ctrl.sv =====
// Allocator sequencer: free-list head, pool size, growth sweep and memory control.
module fla_ctrl
  import fla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                req_mode,
  input  logic [PAGE_W-1:0]   req_page,
  input  logic [GROW_W-1:0]   grow_count,
  output logic                res_valid,
  input  logic                res_ready,
  output fla_result_t         res,
  output logic                ram_re,
  output logic [PAGE_W-1:0]   ram_raddr,
  input  logic [PAGE_W-1:0]   ram_rdata,
  output logic                ram_we,
  output logic [PAGE_W-1:0]   ram_waddr,
  output logic [PAGE_W-1:0]   ram_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_GROW = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]         state, state_next;
  logic [PAGE_W-1:0]  head, head_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic               mode, mode_next;
  logic [PAGE_W-1:0]  page, page_next;
  logic [PAGE_W-1:0]  last, last_next;
  logic [PAGE_W-1:0]  gptr, gptr_next;

  logic               accept;
  logic [TOTAL_W-1:0] room;
  logic [TOTAL_W-1:0] grow_ext;
  logic [TOTAL_W-1:0] add;
  logic [TOTAL_W-1:0] last_sum;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Start the link read for a pop in the accept cycle
  assign ram_re    = accept && (req_mode == MODE_ALLOC) && (head != '0);
  assign ram_raddr = head;

  // Pages the pool can take on this growth
  assign room     = TOTAL_W'(MAX_PAGES) - total;
  assign grow_ext = TOTAL_W'(grow_count);
  assign add      = (grow_ext < room) ? grow_ext : room;
  assign last_sum = total + add - TOTAL_W'(1);

  // Step the sequencer
  always_comb begin
    state_next = state;
    head_next  = head;
    total_next = total;
    mode_next  = mode;
    page_next  = page;
    last_next  = last;
    gptr_next  = gptr;
    res_valid  = 1'b0;
    res        = '0;
    ram_we     = 1'b0;
    ram_waddr  = gptr;
    ram_wdata  = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          mode_next  = req_mode;
          page_next  = req_page;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (mode == MODE_FREE) begin
          if (res_ready) begin
            res_valid       = 1'b1;
            res.total_pages = total;
            if ((page == '0) || ({1'b0, page} >= total)) begin
              res.status = STATUS_BAD_PAGE;
            end else begin
              res.status = STATUS_OK;
              ram_we     = 1'b1;
              ram_waddr  = page;
              ram_wdata  = head;
              head_next  = page;
            end
            state_next = S_IDLE;
          end
        end else if (head != '0) begin
          if (res_ready) begin
            res_valid       = 1'b1;
            res.result_page = head;
            res.status      = STATUS_OK;
            res.total_pages = total;
            head_next       = ram_rdata;
            state_next      = S_IDLE;
          end
        end else if (add == '0) begin
          if (res_ready) begin
            res_valid       = 1'b1;
            res.status      = STATUS_NO_SPACE;
            res.total_pages = total;
            state_next      = S_IDLE;
          end
        end else begin
          last_next  = last_sum[PAGE_W-1:0];
          gptr_next  = total[PAGE_W-1:0];
          state_next = (add == TOTAL_W'(1)) ? S_FIN : S_GROW;
        end
      end
      S_GROW: begin
        // Link each new page below the top one to its predecessor; the lowest one ends the list
        ram_we    = 1'b1;
        ram_waddr = gptr;
        ram_wdata = (gptr == total[PAGE_W-1:0]) ? '0 : gptr - PAGE_W'(1);
        gptr_next = gptr + PAGE_W'(1);
        if (gptr == last - PAGE_W'(1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // Pop the top new page directly
        if (res_ready) begin
          res_valid       = 1'b1;
          res.result_page = last;
          res.status      = STATUS_OK;
          res.total_pages = {1'b0, last} + TOTAL_W'(1);
          total_next      = {1'b0, last} + TOTAL_W'(1);
          head_next       = ({1'b0, last} == total) ? '0 : last - PAGE_W'(1);
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      total <= TOTAL_W'(1);
    end else begin
      state <= state_next;
      head  <= head_next;
      total <= total_next;
    end
  end

  // Request and growth bookkeeping
  always_ff @(posedge clk) begin
    mode <= mode_next;
    page <= page_next;
    last <= last_next;
    gptr <= gptr_next;
  end

endmodule

// ===== bench/tb_free_list_page_allocator.sv =====
// Self-checking testbench for the free-list page allocator: random and directed requests.
`timescale 1ns / 1ps

module tb_free_list_page_allocator;
  import fla_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_CYCLES = 300;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;    // [9:0] page_number, rest zero
  logic                s_tuser = 1'b0;  // [0] mode
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [23:0]         m_tdata;         // [9:0] result_page, [11:10] status,
                                        // [22:12] total_pages, rest zero
  logic                cfg_wen = 1'b0;
  logic [GROW_W-1:0]   cfg_wdata = '0;

  // Allocator state as the bench sees it
  logic [PAGE_W-1:0]   link_mem [MAX_PAGES];
  logic [PAGE_W-1:0]   list_head = '0;
  logic [TOTAL_W-1:0]  pool_total = TOTAL_W'(1);
  logic [GROW_W-1:0]   grow_setting = GROW_RESET;

  fla_result_t         pending_results [$];
  logic [PAGE_W-1:0]   owned_pages [$];
  int unsigned         no_space_count = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         hold_off_left = 0;
  int unsigned         sink_stall_left = 0;
  bit                  hold_off_request = 1'b0;
  bit                  steady_flow = 1'b0;

  free_list_page_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  // Generate the clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("free_list_page_allocator test failed");
      $finish;
    end
  end

  // Random idle length: mostly none or short, a few long; none in steady flow
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (steady_flow) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(8, 4);
    return $urandom_range(30, 15);
  endfunction

  // Push a page onto the head of the free list
  function automatic void push_free_page(logic [PAGE_W-1:0] page);
    link_mem[page] = list_head;
    list_head      = page;
  endfunction

  // Apply one request to the bench state and return the result it must produce
  function automatic fla_result_t apply_request(logic mode, logic [PAGE_W-1:0] page);
    fla_result_t  res;
    int unsigned  room;
    int unsigned  add;
    res = '0;
    res.status = STATUS_OK;
    if (mode == MODE_ALLOC) begin
      // Grow the pool when the list is empty, capped by capacity
      if (list_head == '0) begin
        room = MAX_PAGES - pool_total;
        add  = (grow_setting < room) ? grow_setting : room;
        for (int unsigned i = 0; i < add; i++)
          push_free_page(PAGE_W'(pool_total + i));
        pool_total = pool_total + TOTAL_W'(add);
      end
      if (list_head == '0) begin
        res.status = STATUS_NO_SPACE;
        no_space_count++;
      end else begin
        res.result_page = list_head;
        list_head       = link_mem[list_head];
      end
    end else if (page == '0 || page >= pool_total) begin
      res.status = STATUS_BAD_PAGE;
    end else begin
      push_free_page(page);
    end
    res.total_pages = pool_total;
    return res;
  endfunction

  // Offer one request; on accept, record the result it must produce
  task automatic send_request(input logic mode, input logic [PAGE_W-1:0] page);
    int unsigned gap;
    fla_result_t want;
    gap = idle_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= 16'(page);
    do @(posedge clk); while (!s_tready);
    want = apply_request(mode, page);
    pending_results.push_back(want);
    if (mode == MODE_ALLOC && want.status == STATUS_OK)
      owned_pages.push_back(want.result_page);
  endtask

  // Drop valid and hold until every result is back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_grow_count(input logic [GROW_W-1:0] value);
    wait_for_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen      <= 1'b0;
    grow_setting = value;
  endtask

  task automatic free_owned_page(input int unsigned idx);
    logic [PAGE_W-1:0] page;
    page = owned_pages[idx];
    owned_pages.delete(idx);
    send_request(MODE_FREE, page);
  endtask

  // Page that must be rejected on free: the header or one at or beyond the end of the pool
  function automatic logic [PAGE_W-1:0] pick_bad_page();
    if (pool_total >= MAX_PAGES || $urandom_range(3) == 0) return '0;
    return PAGE_W'($urandom_range(MAX_PAGES - 1, pool_total));
  endfunction

  // Random request: an allocation at the given percentage, else mostly well-formed frees of owned pages, some bad frees
  task automatic issue_random_request(input int unsigned alloc_pct);
    if ($urandom_range(99) < alloc_pct)
      send_request(MODE_ALLOC, PAGE_W'($urandom));
    else if (owned_pages.size() == 0 || $urandom_range(99) < 12)
      send_request(MODE_FREE, pick_bad_page());
    else
      free_owned_page($urandom_range(owned_pages.size() - 1));
  endtask

  task automatic run_mix(input int unsigned count, input int unsigned alloc_pct);
    repeat (count) issue_random_request(alloc_pct);
  endtask

  // Reset state, bad frees, first growth at the default count, LIFO order
  task automatic test_reset_defaults();
    send_request(MODE_FREE, '0);
    send_request(MODE_FREE, '1);
    send_request(MODE_FREE, PAGE_W'(1));
    send_request(MODE_ALLOC, '1);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, PAGE_W'($urandom));
    send_request(MODE_FREE, PAGE_W'(pool_total));
    free_owned_page(0);
    free_owned_page(owned_pages.size() - 1);
    free_owned_page(0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '1);
    send_request(MODE_FREE, '1);
    wait_for_results();
  endtask

  // Drain the list with growth off, then grow by one page, by 128, then by a random count in steady flow
  task automatic test_grow_settings();
    set_grow_count(GROW_W'(0));
    run_mix(150, 80);
    set_grow_count(GROW_W'(1));
    run_mix(120, 70);
    set_grow_count(GROW_W'(128));
    run_mix(80, 60);
    set_grow_count(GROW_W'($urandom_range(128, 1)));
    steady_flow = 1'b1;
    run_mix(80, 60);
    steady_flow = 1'b0;
  endtask

  // Hold the result side off so the block backs up and stalls its input
  task automatic test_backpressure();
    set_grow_count(GROW_W'($urandom_range(128, 1)));
    hold_off_request = 1'b1;
    run_mix(80, 50);
    wait_for_results();
  endtask

  // Allocate until the pool is at capacity and allocations run out of space
  task automatic test_fill_to_capacity();
    int unsigned sent;
    int unsigned base_no_space;
    set_grow_count(GROW_W'(128));
    sent          = 0;
    base_no_space = no_space_count;
    while (sent < 1400 &&
           !(pool_total == MAX_PAGES && no_space_count >= base_no_space + 6)) begin
      issue_random_request(100);
      sent++;
    end
    set_grow_count(GROW_W'($urandom_range(128, 1)));
    run_mix(60, 45);
  endtask

  // Free one page twice; the list then loops on that page
  task automatic test_double_free();
    logic [PAGE_W-1:0] page;
    wait_for_results();
    send_request(MODE_ALLOC, PAGE_W'($urandom));
    if (owned_pages.size() == 0) begin
      wait_for_results();
      return;
    end
    page = owned_pages[owned_pages.size() - 1];
    free_owned_page(owned_pages.size() - 1);
    send_request(MODE_FREE, page);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '1);
    send_request(MODE_FREE, '0);
    send_request(MODE_ALLOC, PAGE_W'($urandom));
    wait_for_results();
  endtask

  // Compare one result with the oldest outstanding request
  task automatic compare_result(input logic [23:0] data);
    fla_result_t want;
    fla_result_t got;
    got = fla_result_t'(data[TOTAL_W+STATUS_W+PAGE_W-1:0]);
    if (pending_results.size() == 0) begin
      $error("result with no request outstanding: m_tdata %h", data);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.result_page !== want.result_page) begin
      $error("result_page mismatch: expected %0d, got %0d", want.result_page, got.result_page);
      mismatch_count++;
    end
    if (got.status !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, got.status);
      mismatch_count++;
    end
    if (got.total_pages !== want.total_pages) begin
      $error("total_pages mismatch: expected %0d, got %0d", want.total_pages, got.total_pages);
      mismatch_count++;
    end
  endtask

  // Check results and drive ready with random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        compare_result(m_tdata);
      if (hold_off_request) begin
        hold_off_left    = HOLD_CYCLES;
        hold_off_request = 1'b0;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_tready <= 1'b0;
      end else if (sink_stall_left > 0) begin
        sink_stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_stall_left = idle_length();
      end
    end
  end

  // Run the tests in turn
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_grow_settings();
    test_backpressure();
    test_fill_to_capacity();
    test_double_free();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("free_list_page_allocator test passed");
    else
      $display("free_list_page_allocator test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/fla_pkg.sv
design/fla_link_ram.sv
design/fla_ctrl.sv
design/free_list_page_allocator.sv
bench/tb_free_list_page_allocator.sv
